// ===== rtl/core/pifc_pkg.sv =====
// Shared widths, a reset value, a stage type for the finite cylinder point test.
package pifc_pkg;

   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 8;
   localparam int THR_W      = 16;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

   localparam int STAGES  = 8;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int HALF_W  = (MAG_W + 1) / 2;
   localparam int HIGH_W  = MAG_W - HALF_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int C2_W    = SQ_W + 2;
   localparam int E2_W    = DOT_W;
   localparam int E2L_W   = (E2_W + 1) / 2;
   localparam int E2H_W   = E2_W - E2L_W;
   localparam int LIM_W   = E2_W + THR_W;
   localparam int SLIM_W  = LIM_W + FRAC_BITS;
   localparam int CMP_W   = ((C2_W > SLIM_W) ? C2_W : SLIM_W) + 1;

   typedef struct packed {
      logic                       degen;
      logic                       d1_neg;
      logic                       d2_pos;
      logic signed [CROSS_W-1:0]  cx;
      logic signed [CROSS_W-1:0]  cy;
      logic signed [CROSS_W-1:0]  cz;
      logic        [E2_W-1:0]     e2;
   } pifc_front_type;

endpackage

// ===== rtl/core/pifc_flow.sv =====
// Valid bits and per-stage load enables for the pipeline, with bubble collapse.
module pifc_flow
   import pifc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAGES-1:0] load_en
);

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   always_comb begin
      load_en[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load_en[k] = !vld_ff[k] || load_en[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (load_en[0]) begin
         vld_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load_en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !load_en[0];
   assign rsp_valid = vld_ff[STAGES-1];

endmodule

// ===== rtl/core/pifc_front.sv =====
// Front stages: axis and probe differences, products, dot products and cross product.
module pifc_front
   import pifc_pkg::*;
(
   input  logic                         clock,
   input  logic [2:0]                   load_en,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] a_z,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] b_z,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   input  logic signed [COORD_BITS-1:0] p_z,
   output pifc_front_type               front
);

   logic signed [DIFF_W-1:0] ex_ff, ey_ff, ez_ff, vx_ff, vy_ff, vz_ff, ux_ff, uy_ff, uz_ff;

   logic signed [PROD_W-1:0] eyvz_ff, ezvy_ff, ezvx_ff, exvz_ff, exvy_ff, eyvx_ff;
   logic signed [PROD_W-1:0] d1x_ff, d1y_ff, d1z_ff, d2x_ff, d2y_ff, d2z_ff;
   logic signed [PROD_W-1:0] exx_ff, eyy_ff, ezz_ff;
   logic                     degen_ff;
   logic                     degen_in;

   logic signed [DOT_W-1:0]  d1_in, d2_in, e2_in;
   pifc_front_type           front_ff;
   pifc_front_type           front_in;

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         ex_ff <= DIFF_W'(b_x) - DIFF_W'(a_x);
         ey_ff <= DIFF_W'(b_y) - DIFF_W'(a_y);
         ez_ff <= DIFF_W'(b_z) - DIFF_W'(a_z);
         vx_ff <= DIFF_W'(p_x) - DIFF_W'(a_x);
         vy_ff <= DIFF_W'(p_y) - DIFF_W'(a_y);
         vz_ff <= DIFF_W'(p_z) - DIFF_W'(a_z);
         ux_ff <= DIFF_W'(p_x) - DIFF_W'(b_x);
         uy_ff <= DIFF_W'(p_y) - DIFF_W'(b_y);
         uz_ff <= DIFF_W'(p_z) - DIFF_W'(b_z);
      end
   end

   assign degen_in = ((ex_ff | ey_ff | ez_ff) == '0) || ((vx_ff | vy_ff | vz_ff) == '0) ||
                     ((ux_ff | uy_ff | uz_ff) == '0);

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         eyvz_ff  <= ey_ff * vz_ff;
         ezvy_ff  <= ez_ff * vy_ff;
         ezvx_ff  <= ez_ff * vx_ff;
         exvz_ff  <= ex_ff * vz_ff;
         exvy_ff  <= ex_ff * vy_ff;
         eyvx_ff  <= ey_ff * vx_ff;
         d1x_ff   <= vx_ff * ex_ff;
         d1y_ff   <= vy_ff * ey_ff;
         d1z_ff   <= vz_ff * ez_ff;
         d2x_ff   <= ux_ff * ex_ff;
         d2y_ff   <= uy_ff * ey_ff;
         d2z_ff   <= uz_ff * ez_ff;
         exx_ff   <= ex_ff * ex_ff;
         eyy_ff   <= ey_ff * ey_ff;
         ezz_ff   <= ez_ff * ez_ff;
         degen_ff <= degen_in;
      end
   end

   always_comb begin
      d1_in = DOT_W'(d1x_ff) + DOT_W'(d1y_ff) + DOT_W'(d1z_ff);
      d2_in = DOT_W'(d2x_ff) + DOT_W'(d2y_ff) + DOT_W'(d2z_ff);
      e2_in = DOT_W'(exx_ff) + DOT_W'(eyy_ff) + DOT_W'(ezz_ff);
      front_in.degen  = degen_ff;
      front_in.d1_neg = d1_in[DOT_W-1];
      front_in.d2_pos = !d2_in[DOT_W-1] && (d2_in != '0);
      front_in.cx     = CROSS_W'(eyvz_ff) - CROSS_W'(ezvy_ff);
      front_in.cy     = CROSS_W'(ezvx_ff) - CROSS_W'(exvz_ff);
      front_in.cz     = CROSS_W'(exvy_ff) - CROSS_W'(eyvx_ff);
      front_in.e2     = e2_in;
   end

   always_ff @(posedge clock) begin
      if (load_en[2]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// ===== rtl/core/pifc_dist.sv =====
// Back stages: squared cross product, scaled radius limit and final compare.
module pifc_dist
   import pifc_pkg::*;
(
   input  logic             clock,
   input  logic [4:0]       load_en,
   input  pifc_front_type   front,
   input  logic [THR_W-1:0] thr,
   output logic             hit
);

   logic [MAG_W-1:0]          mag_ff [3];
   logic [MAG_W-1:0]          mag_in [3];
   logic [E2H_W+THR_W-1:0]    lim_hi_ff;
   logic [E2L_W+THR_W-1:0]    lim_lo_ff;
   logic                      ok3_ff;

   logic [2*HIGH_W-1:0]       hh_ff [3];
   logic [MAG_W-1:0]          hl_ff [3];
   logic [2*HALF_W-1:0]       ll_ff [3];
   logic [LIM_W-1:0]          lim4_ff;
   logic                      ok4_ff;

   logic [SQ_W-1:0]           sq_ff [3];
   logic [LIM_W-1:0]          lim5_ff;
   logic                      ok5_ff;

   logic [C2_W-1:0]           c2_ff;
   logic [LIM_W-1:0]          lim6_ff;
   logic                      ok6_ff;

   logic                      inside_ff;
   logic                      inside_in;

   logic signed [CROSS_W-1:0] cr [3];

   always_comb begin
      cr[0] = front.cx;
      cr[1] = front.cy;
      cr[2] = front.cz;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         mag_ff    <= mag_in;
         lim_hi_ff <= front.e2[E2_W-1:E2L_W] * thr;
         lim_lo_ff <= front.e2[E2L_W-1:0] * thr;
         ok3_ff    <= !front.degen && !front.d1_neg && !front.d2_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= mag_ff[i][MAG_W-1:HALF_W] * mag_ff[i][MAG_W-1:HALF_W];
            hl_ff[i] <= mag_ff[i][MAG_W-1:HALF_W] * mag_ff[i][HALF_W-1:0];
            ll_ff[i] <= mag_ff[i][HALF_W-1:0] * mag_ff[i][HALF_W-1:0];
         end
         lim4_ff <= (LIM_W'(lim_hi_ff) << E2L_W) + LIM_W'(lim_lo_ff);
         ok4_ff  <= ok3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[2]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (SQ_W'(hh_ff[i]) << (2 * HALF_W)) + (SQ_W'(hl_ff[i]) << (HALF_W + 1)) +
                        SQ_W'(ll_ff[i]);
         end
         lim5_ff <= lim4_ff;
         ok5_ff  <= ok4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[3]) begin
         c2_ff   <= C2_W'(sq_ff[0]) + C2_W'(sq_ff[1]) + C2_W'(sq_ff[2]);
         lim6_ff <= lim5_ff;
         ok6_ff  <= ok5_ff;
      end
   end

   assign inside_in = ok6_ff && (CMP_W'(c2_ff) < (CMP_W'(lim6_ff) << FRAC_BITS));

   always_ff @(posedge clock) begin
      if (load_en[4]) begin
         inside_ff <= inside_in;
      end
   end

   assign hit = inside_ff;

endmodule

// ===== rtl/core/point_in_finite_cylinder_test.sv =====
// Top level of the pipelined point in finite cylinder test.
//
//   channel | ports                      | accepted when
//   --------+----------------------------+---------------------------
//   request | req_valid, req_stall, 9 x  | req_valid && !req_stall
//   result  | rsp_valid, rsp_stall, 1 x  | rsp_valid && !rsp_stall
//   csr     | csr_valid, csr_ready, data | csr_valid && csr_ready
//
// Eight register stages. One word a cycle is sustained while the result side does not
// stall, set by the fifteen 21x21 multipliers of stage two and the split squares of
// stages five and six.
// Synchronous reset empties the pipeline and sets the threshold to 1.0.
// A stall at the result port backs up only as far as the first empty stage.
module point_in_finite_cylinder_test
   import pifc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_axis_start_x,
   input  logic signed [COORD_BITS-1:0] req_axis_start_y,
   input  logic signed [COORD_BITS-1:0] req_axis_start_z,
   input  logic signed [COORD_BITS-1:0] req_axis_end_x,
   input  logic signed [COORD_BITS-1:0] req_axis_end_y,
   input  logic signed [COORD_BITS-1:0] req_axis_end_z,
   input  logic signed [COORD_BITS-1:0] req_probe_x,
   input  logic signed [COORD_BITS-1:0] req_probe_y,
   input  logic signed [COORD_BITS-1:0] req_probe_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_inside_res,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [THR_W-1:0]             csr_radius_sq_threshold
);

   logic [THR_W-1:0]  thr_ff;
   logic [STAGES-1:0] load_en;
   pifc_front_type    front;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_radius_sq_threshold;
      end
   end

   assign csr_ready = 1'b1;

   pifc_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .load_en   (load_en)
   );

   pifc_front u_front (
      .clock   (clock),
      .load_en (load_en[2:0]),
      .a_x     (req_axis_start_x),
      .a_y     (req_axis_start_y),
      .a_z     (req_axis_start_z),
      .b_x     (req_axis_end_x),
      .b_y     (req_axis_end_y),
      .b_z     (req_axis_end_z),
      .p_x     (req_probe_x),
      .p_y     (req_probe_y),
      .p_z     (req_probe_z),
      .front   (front)
   );

   pifc_dist u_dist (
      .clock   (clock),
      .load_en (load_en[STAGES-1:3]),
      .front   (front),
      .thr     (thr_ff),
      .hit     (rsp_inside_res)
   );

endmodule

// ===== rtl/core/pifc_checker.sv =====
// Port-level checks for the point in finite cylinder test, bound to the top level.
module pifc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result side can drain");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inside_res)))
      else $error("stalled result word changed");

endmodule

bind point_in_finite_cylinder_test pifc_checker u_pifc_checker (.*);
